// ===== rtl/core/dmac_pkg.sv =====
// ----------------------------------------------------------------------------
// dmac_pkg
// Shared types and defaults for the moving-average crossover signal block.
// ----------------------------------------------------------------------------
package dmac_pkg;

  localparam int unsigned SHORT_LEN_DEF  = 10;
  localparam int unsigned LONG_LEN_DEF   = 50;
  localparam int unsigned PRICE_BITS_DEF = 32;

  typedef enum logic [1:0] {
    SIG_HOLD = 2'd0,
    SIG_BUY  = 2'd1,
    SIG_SELL = 2'd2
  } signal_e;

  // Control that travels alongside the data between pipeline stages
  typedef struct packed {
    logic valid;
    logic warm;
  } stage_ctl_t;

endpackage

// ===== rtl/core/dmac_if.sv =====
// ----------------------------------------------------------------------------
// dmac_price_if / dmac_result_if
// Valid/ready channels for price requests and crossover results.
// ----------------------------------------------------------------------------
interface dmac_price_if #(
  parameter int unsigned PriceBits = 32
);
  logic                 valid;
  logic                 ready;
  logic [PriceBits-1:0] price;

  modport source (output valid, output price, input ready);
  modport sink   (input valid, input price, output ready);
endinterface

interface dmac_result_if;
  logic       valid;
  logic       ready;
  logic [1:0] signal;
  logic       warmed_up;

  modport source (output valid, output signal, output warmed_up, input ready);
  modport sink   (input valid, input signal, input warmed_up, output ready);
endinterface

// ===== rtl/core/dmac_window.sv =====
// ----------------------------------------------------------------------------
// dmac_window
// Price shift line, running short/long sums and warm-up counter.
// ----------------------------------------------------------------------------
module dmac_window
  import dmac_pkg::*;
#(
  parameter int unsigned ShortLen  = SHORT_LEN_DEF,
  parameter int unsigned LongLen   = LONG_LEN_DEF,
  parameter int unsigned PriceBits = PRICE_BITS_DEF,
  localparam int unsigned BufLen   = (ShortLen > LongLen) ? ShortLen : LongLen,
  localparam int unsigned SsW      = PriceBits + $clog2(ShortLen + 1),
  localparam int unsigned LsW      = PriceBits + $clog2(LongLen + 1)
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 adv_i,
  input  logic                 valid_i,
  input  logic [PriceBits-1:0] price_i,
  output stage_ctl_t           ctl_o,
  output logic [SsW-1:0]       short_sum_o,
  output logic [LsW-1:0]       long_sum_o
);

  localparam int unsigned FcW = $clog2(BufLen + 1);
  localparam logic [FcW-1:0] BufCnt   = FcW'(BufLen);
  localparam logic [FcW-1:0] ShortCnt = FcW'(ShortLen);
  localparam logic [FcW-1:0] LongCnt  = FcW'(LongLen);

  logic [PriceBits-1:0] taps_q [BufLen];
  logic [FcW-1:0]       fill_q, fill_d;
  logic [SsW-1:0]       short_q, short_d;
  logic [LsW-1:0]       long_q, long_d;
  stage_ctl_t           ctl_q;
  logic                 step;

  assign step = adv_i & valid_i;

  always_comb begin
    fill_d  = (fill_q == BufCnt) ? fill_q : fill_q + FcW'(1);
    // Drop the sample leaving each window once that window has filled
    short_d = short_q + SsW'(price_i)
            - ((fill_q >= ShortCnt) ? SsW'(taps_q[ShortLen-1]) : '0);
    long_d  = long_q + LsW'(price_i)
            - ((fill_q >= LongCnt) ? LsW'(taps_q[LongLen-1]) : '0);
  end

  always_ff @(posedge clk_i) begin
    if (step) begin
      taps_q[0] <= price_i;
      for (int i = 1; i < BufLen; i++) begin
        taps_q[i] <= taps_q[i-1];
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fill_q  <= '0;
      short_q <= '0;
      long_q  <= '0;
      ctl_q   <= '0;
    end else if (adv_i) begin
      ctl_q.valid <= valid_i;
      if (valid_i) begin
        fill_q     <= fill_d;
        short_q    <= short_d;
        long_q     <= long_d;
        ctl_q.warm <= (fill_d == BufCnt);
      end
    end
  end

  assign ctl_o       = ctl_q;
  assign short_sum_o = short_q;
  assign long_sum_o  = long_q;

endmodule

// ===== rtl/core/dmac_product.sv =====
// ----------------------------------------------------------------------------
// dmac_product
// Cross-multiplies the window sums so the averages compare without division.
// ----------------------------------------------------------------------------
module dmac_product
  import dmac_pkg::*;
#(
  parameter int unsigned ShortLen  = SHORT_LEN_DEF,
  parameter int unsigned LongLen   = LONG_LEN_DEF,
  parameter int unsigned PriceBits = PRICE_BITS_DEF,
  localparam int unsigned SsW      = PriceBits + $clog2(ShortLen + 1),
  localparam int unsigned LsW      = PriceBits + $clog2(LongLen + 1),
  localparam int unsigned PrW      = PriceBits + $clog2(ShortLen + 1) + $clog2(LongLen + 1)
) (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           adv_i,
  input  stage_ctl_t     ctl_i,
  input  logic [SsW-1:0] short_sum_i,
  input  logic [LsW-1:0] long_sum_i,
  output stage_ctl_t     ctl_o,
  output logic [PrW-1:0] lhs_o,
  output logic [PrW-1:0] rhs_o
);

  localparam logic [PrW-1:0] LongK  = PrW'(LongLen);
  localparam logic [PrW-1:0] ShortK = PrW'(ShortLen);

  stage_ctl_t     ctl_q;
  logic [PrW-1:0] lhs_q, rhs_q;

  always_ff @(posedge clk_i) begin
    if (adv_i) begin
      lhs_q <= PrW'(short_sum_i) * LongK;
      rhs_q <= PrW'(long_sum_i) * ShortK;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ctl_q <= '0;
    end else if (adv_i) begin
      ctl_q <= ctl_i;
    end
  end

  assign ctl_o = ctl_q;
  assign lhs_o = lhs_q;
  assign rhs_o = rhs_q;

endmodule

// ===== rtl/core/dmac_decide.sv =====
// ----------------------------------------------------------------------------
// dmac_decide
// Crossing detection against the stored relation, and the result register.
// ----------------------------------------------------------------------------
module dmac_decide
  import dmac_pkg::*;
#(
  parameter int unsigned PrW = 64
) (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           adv_i,
  input  stage_ctl_t     ctl_i,
  input  logic [PrW-1:0] lhs_i,
  input  logic [PrW-1:0] rhs_i,
  output logic           valid_o,
  output signal_e        signal_o,
  output logic           warmed_up_o
);

  logic    above, below;
  logic    prev_above_q, prev_below_q;
  logic    valid_q, warm_q;
  signal_e sig_d, sig_q;

  assign above = lhs_i > rhs_i;
  assign below = lhs_i < rhs_i;

  always_comb begin
    sig_d = SIG_HOLD;
    if (ctl_i.warm) begin
      priority if (prev_below_q && above) begin
        sig_d = SIG_BUY;
      end else if (prev_above_q && below) begin
        sig_d = SIG_SELL;
      end else begin
        sig_d = SIG_HOLD;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      prev_above_q <= 1'b0;
      prev_below_q <= 1'b0;
      valid_q      <= 1'b0;
    end else if (adv_i) begin
      valid_q <= ctl_i.valid;
      // Relation only moves on warmed-up requests
      if (ctl_i.valid && ctl_i.warm) begin
        prev_above_q <= above;
        prev_below_q <= below;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv_i) begin
      sig_q  <= sig_d;
      warm_q <= ctl_i.warm;
    end
  end

  assign valid_o     = valid_q;
  assign signal_o    = sig_q;
  assign warmed_up_o = warm_q;

endmodule

// ===== rtl/core/dual_moving_average_crossover.sv =====
// ----------------------------------------------------------------------------
// dual_moving_average_crossover
// Moving-average crossover signal over a stream of integer prices.
// ----------------------------------------------------------------------------
// One result per price request, one request per clock sustained unless stalled;
// acceptance to result runs through four registers: input register, window
// sums, cross-multiply, crossing decision in the result register. The whole
// pipeline stalls only while a result sits unaccepted, so in_i.ready follows
// out_o.ready when the result register is full. Results are hold with
// warmed_up low until max(ShortLen, LongLen) prices have been seen; the
// averages then compare exactly via short_sum*LongLen against long_sum*ShortLen.
module dual_moving_average_crossover
  import dmac_pkg::*;
#(
  parameter int unsigned ShortLen  = SHORT_LEN_DEF,
  parameter int unsigned LongLen   = LONG_LEN_DEF,
  parameter int unsigned PriceBits = PRICE_BITS_DEF
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  dmac_price_if.sink           in_i,
  dmac_result_if.source        out_o
);

  localparam int unsigned SsW = PriceBits + $clog2(ShortLen + 1);
  localparam int unsigned LsW = PriceBits + $clog2(LongLen + 1);
  localparam int unsigned PrW = PriceBits + $clog2(ShortLen + 1) + $clog2(LongLen + 1);

  logic                 adv;
  logic                 in_valid_q;
  logic [PriceBits-1:0] price_q;
  stage_ctl_t           win_ctl, prod_ctl;
  logic [SsW-1:0]       short_sum;
  logic [LsW-1:0]       long_sum;
  logic [PrW-1:0]       lhs, rhs;
  logic                 out_valid;
  signal_e              out_sig;
  logic                 out_warm;

  // Advance every stage unless a finished result is held back
  assign adv        = !out_valid || out_o.ready;
  assign in_i.ready = adv;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (adv) begin
      in_valid_q <= in_i.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      price_q <= in_i.price[PriceBits-1:0];
    end
  end

  dmac_window #(
    .ShortLen  (ShortLen),
    .LongLen   (LongLen),
    .PriceBits (PriceBits)
  ) u_window (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .adv_i       (adv),
    .valid_i     (in_valid_q),
    .price_i     (price_q),
    .ctl_o       (win_ctl),
    .short_sum_o (short_sum),
    .long_sum_o  (long_sum)
  );

  dmac_product #(
    .ShortLen  (ShortLen),
    .LongLen   (LongLen),
    .PriceBits (PriceBits)
  ) u_product (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .adv_i       (adv),
    .ctl_i       (win_ctl),
    .short_sum_i (short_sum),
    .long_sum_i  (long_sum),
    .ctl_o       (prod_ctl),
    .lhs_o       (lhs),
    .rhs_o       (rhs)
  );

  dmac_decide #(
    .PrW (PrW)
  ) u_decide (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .adv_i       (adv),
    .ctl_i       (prod_ctl),
    .lhs_i       (lhs),
    .rhs_i       (rhs),
    .valid_o     (out_valid),
    .signal_o    (out_sig),
    .warmed_up_o (out_warm)
  );

  assign out_o.valid     = out_valid;
  assign out_o.signal    = out_sig;
  assign out_o.warmed_up = out_warm;

endmodule

// ===== rtl/core/dmac_checker.sv =====
// ----------------------------------------------------------------------------
// dmac_checker
// Port-level checks on the crossover result stream.
// ----------------------------------------------------------------------------
module dmac_checker
  import dmac_pkg::*;
(
  input logic       clk_i,
  input logic       rst_ni,
  input logic       out_valid_i,
  input logic       out_ready_i,
  input logic [1:0] out_signal_i,
  input logic       out_warmed_up_i
);

  logic out_take;
  logic seen_warm_q;
  logic last_buy_q, last_sell_q;

  assign out_take = out_valid_i && out_ready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      seen_warm_q <= 1'b0;
      last_buy_q  <= 1'b0;
      last_sell_q <= 1'b0;
    end else if (out_take) begin
      seen_warm_q <= seen_warm_q || out_warmed_up_i;
      last_buy_q  <= (out_signal_i == SIG_BUY);
      last_sell_q <= (out_signal_i == SIG_SELL);
    end
  end

  // A stalled result holds its payload
  a_hold_stalled: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=>
      out_valid_i && $stable(out_signal_i) && $stable(out_warmed_up_i))
    else $error("stalled result changed");

  // No crossing is reported before both windows are full
  a_hold_cold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_warmed_up_i |-> out_signal_i == SIG_HOLD)
    else $error("signal before warm-up");

  // Once warm, every later result stays warm
  a_warm_sticky: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && seen_warm_q |-> out_warmed_up_i)
    else $error("warm-up lost");

  // The same crossing cannot repeat on the next result
  a_no_repeat: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && (last_buy_q || last_sell_q) |->
      !(last_buy_q && out_signal_i == SIG_BUY) &&
      !(last_sell_q && out_signal_i == SIG_SELL))
    else $error("repeated crossing");

endmodule

bind dual_moving_average_crossover dmac_checker u_dmac_checker (
  .clk_i           (clk_i),
  .rst_ni          (rst_ni),
  .out_valid_i     (out_o.valid),
  .out_ready_i     (out_o.ready),
  .out_signal_i    (out_o.signal),
  .out_warmed_up_i (out_o.warmed_up)
);

// ===== test/dual_moving_average_crossover_test.sv =====
// ----------------------------------------------------------------------------
// dual_moving_average_crossover_test
// Self-checking bench for the moving-average crossover block. Prices go in
// over the request channel and every accepted request is run through a
// local model of the two window sums and the crossing rule. Results are
// checked in order against that model, most tests idling both channels at random.
// ----------------------------------------------------------------------------
module dual_moving_average_crossover_test;
  timeunit 1ns;
  timeprecision 1ps;

  import dmac_pkg::*;

  localparam int unsigned ShortLen  = SHORT_LEN_DEF;
  localparam int unsigned LongLen   = LONG_LEN_DEF;
  localparam int unsigned PriceBits = PRICE_BITS_DEF;
  localparam int unsigned Depth     = (ShortLen > LongLen) ? ShortLen : LongLen;
  localparam longint      PriceMax  = (longint'(1) << PriceBits) - 1;

  typedef logic [PriceBits-1:0] price_t;

  typedef struct packed {
    signal_e sig;
    logic    warm;
  } crossover_t;

  logic clk_i  = 1'b0;
  logic rst_ni = 1'b0;

  dmac_price_if #(.PriceBits(PriceBits)) price_ch ();
  dmac_result_if                         result_ch ();

  dual_moving_average_crossover #(
    .ShortLen (ShortLen),
    .LongLen  (LongLen),
    .PriceBits(PriceBits)
  ) uut (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .in_i  (price_ch.sink),
    .out_o (result_ch.source)
  );

  always begin
    clk_i = 1'b0;
    #4;
    clk_i = 1'b1;
    #4;
  end

  // Window model
  price_t            price_hist [Depth] = '{default: '0};
  longint unsigned   short_total = 0;
  longint unsigned   long_total  = 0;
  int unsigned       seen_count  = 0;
  int unsigned       head_slot   = 0;
  bit                was_above   = 1'b0;
  bit                was_below   = 1'b0;

  crossover_t        pending_signals [$];

  int unsigned src_gap_max   = 5;
  int unsigned snk_stall_max = 5;
  int unsigned prices_sent   = 0;
  int unsigned results_seen  = 0;
  int unsigned buys_seen     = 0;
  int unsigned sells_seen    = 0;
  int unsigned failures      = 0;

  // Random walk state for market-like prices
  longint      walk_level = 64'd100000;
  longint      walk_slope = 0;
  int unsigned walk_left  = 0;

  function automatic crossover_t next_crossover(price_t p);
    crossover_t      r;
    int unsigned     drop_s;
    int unsigned     drop_l;
    longint unsigned lhs;
    longint unsigned rhs;
    bit              above;
    bit              below;
    drop_s = (head_slot + Depth - ShortLen) % Depth;
    drop_l = (head_slot + Depth - LongLen) % Depth;
    short_total = short_total - price_hist[drop_s] + p;
    long_total  = long_total - price_hist[drop_l] + p;
    price_hist[head_slot] = p;
    head_slot = (head_slot + 1) % Depth;
    if (seen_count < Depth) seen_count++;
    r.sig  = SIG_HOLD;
    r.warm = (seen_count >= Depth);
    if (r.warm) begin
      // compare averages without dividing
      lhs   = short_total * LongLen;
      rhs   = long_total * ShortLen;
      above = lhs > rhs;
      below = lhs < rhs;
      if (was_below && above) begin
        r.sig = SIG_BUY;
      end else if (was_above && below) begin
        r.sig = SIG_SELL;
      end
      was_above = above;
      was_below = below;
    end
    return r;
  endfunction

  function automatic price_t next_market_price();
    int unsigned roll;
    longint      mag;
    if (walk_left == 0) begin
      walk_left = $urandom_range(60, 4);
      mag = ($urandom_range(3, 0) == 0) ? longint'($urandom_range(1 << 22, 0))
                                        : longint'($urandom_range(1500, 0));
      walk_slope = $urandom_range(1, 0) ? mag : -mag;
      // jump to a fresh level now and then so the upper bits move too
      if ($urandom_range(7, 0) == 0) walk_level = longint'($urandom);
    end
    walk_left--;
    roll = $urandom_range(99, 0);
    if (roll < 8) return price_t'($urandom);
    if (roll < 10) return '0;
    if (roll < 12) return '1;
    walk_level += walk_slope + longint'($urandom_range(64, 0)) - 32;
    if (walk_level < 0) walk_level = 0;
    if (walk_level > PriceMax) walk_level = PriceMax;
    return price_t'(walk_level);
  endfunction

  // Call at a rising edge; returns at the edge that accepts the request.
  task automatic send_price(input price_t p);
    int unsigned gap;
    gap = $urandom_range(src_gap_max, 0);
    if (gap != 0) begin
      price_ch.valid <= 1'b0;
      price_ch.price <= price_t'($urandom);
      repeat (gap) @(posedge clk_i);
    end
    price_ch.valid <= 1'b1;
    price_ch.price <= p;
    do @(posedge clk_i); while (!price_ch.ready);
    pending_signals.insert(pending_signals.size(), next_crossover(p));
    prices_sent++;
  endtask

  // Result side: stall, accept, compare with the oldest prediction.
  initial begin
    int unsigned stall;
    crossover_t  want;
    result_ch.ready <= 1'b0;
    wait (rst_ni === 1'b1);
    @(posedge clk_i);
    forever begin
      stall = $urandom_range(snk_stall_max, 0);
      if (stall != 0) begin
        result_ch.ready <= 1'b0;
        repeat (stall) @(posedge clk_i);
      end
      result_ch.ready <= 1'b1;
      do @(posedge clk_i); while (result_ch.valid !== 1'b1);
      results_seen++;
      if (result_ch.signal === SIG_BUY) buys_seen++;
      if (result_ch.signal === SIG_SELL) sells_seen++;
      if (pending_signals.size() == 0) begin
        $error("result with no price request outstanding: signal %0d warmed_up %0d",
               result_ch.signal, result_ch.warmed_up);
        failures++;
      end else begin
        want = pending_signals.pop_front();
        if (result_ch.signal !== want.sig) begin
          $error("signal: expected %0d, actual %0d", want.sig, result_ch.signal);
          failures++;
        end
        if (result_ch.warmed_up !== want.warm) begin
          $error("warmed_up: expected %0d, actual %0d", want.warm, result_ch.warmed_up);
          failures++;
        end
      end
    end
  end

  // Field extremes lead the warm-up; the window fills with short below long,
  // yet the first valid step must still hold.
  task automatic test_warm_up();
    price_t lead [4] = '{'0, '1, price_t'(32'hAAAA_AAAA), price_t'(32'h5555_5555)};
    src_gap_max   = 5;
    snk_stall_max = 5;
    foreach (lead[i]) send_price(lead[i]);
    repeat (Depth - 4) send_price(price_t'(1000));
  endtask

  // Flush the extremes to reach equal averages, then step above: below,
  // equal, above must give no buy.
  task automatic test_through_equality();
    repeat (4) send_price(price_t'(1000));
    send_price(price_t'(2000));
  endtask

  // From above: stay above, then cross down (sell), up (buy), down (sell).
  task automatic test_direct_crossings();
    send_price(price_t'(500));
    send_price(price_t'(0));
    send_price(price_t'(2000));
    send_price(price_t'(0));
  endtask

  task automatic test_trending_prices();
    src_gap_max   = 5;
    snk_stall_max = 5;
    repeat (1300) send_price(next_market_price());
  endtask

  task automatic test_back_to_back();
    src_gap_max   = 0;
    snk_stall_max = 0;
    repeat (300) send_price(next_market_price());
  endtask

  task automatic test_result_backpressure();
    src_gap_max   = 0;
    snk_stall_max = 5;
    repeat (150) send_price(next_market_price());
  endtask

  task automatic test_sparse_requests();
    src_gap_max   = 5;
    snk_stall_max = 0;
    repeat (150) send_price(next_market_price());
  endtask

  initial begin
    int unsigned drain;
    price_ch.valid <= 1'b0;
    price_ch.price <= '0;
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_warm_up();
    test_through_equality();
    test_direct_crossings();
    test_trending_prices();
    test_back_to_back();
    test_result_backpressure();
    test_sparse_requests();

    price_ch.valid <= 1'b0;
    snk_stall_max = 5;
    drain = 0;
    while (pending_signals.size() != 0 && drain < 500) begin
      @(posedge clk_i);
      drain++;
    end
    repeat (8) @(posedge clk_i);
    if (pending_signals.size() != 0) begin
      $error("%0d results never arrived", pending_signals.size());
      failures++;
    end

    $display("Ran %0d prices through warm-up, equality, direct crossings and random trends;",
             prices_sent);
    $display("checked %0d results, %0d buy and %0d sell, with both sides idling at random.",
             results_seen, buys_seen, sells_seen);
    if (failures == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

  initial begin
    #2_000_000;
    $display("Verification failed");
    $finish;
  end

endmodule
